### hw/rtl/mra_pkg.sv
// Shared types, codes and constants of the mouse report aggregator.
`timescale 1ns / 1ps
package mra_pkg;

    localparam int ACC_WIDTH_DEF = 24;
    localparam int DIV_W         = 16;
    localparam int PLAN_W        = 14;
    localparam logic [13:0] PLAN_MAX = 14'd16383;

    // Event opcodes
    localparam logic [3:0] OP_MOVE    = 4'd0;
    localparam logic [3:0] OP_VSCROLL = 4'd1;
    localparam logic [3:0] OP_HSCROLL = 4'd2;
    localparam logic [3:0] OP_BUTTON  = 4'd3;
    localparam logic [3:0] OP_MASK    = 4'd4;
    localparam logic [3:0] OP_PLAN    = 4'd5;
    localparam logic [3:0] OP_TICK    = 4'd6;
    localparam logic [3:0] OP_LINK_UP = 4'd7;
    localparam logic [3:0] OP_LINK_DN = 4'd8;

    // Link modes
    localparam logic [1:0] LINK_DISC   = 2'd0;
    localparam logic [1:0] LINK_ACTIVE = 2'd1;
    localparam logic [1:0] LINK_IDLE   = 2'd2;

    // Link change codes of the report
    localparam logic [1:0] LC_NONE   = 2'd0;
    localparam logic [1:0] LC_IDLE   = 2'd1;
    localparam logic [1:0] LC_ACTIVE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_HSCROLL_EN = 2'd0;
    localparam logic [1:0] CFG_RATE       = 2'd1;
    localparam logic [1:0] CFG_IDLE_THR   = 2'd2;

    // Divider operand selection
    localparam logic [1:0] DSEL_TOTAL = 2'd0;
    localparam logic [1:0] DSEL_X     = 2'd1;
    localparam logic [1:0] DSEL_Y     = 2'd2;

    typedef struct packed {
        logic       load_item;
        logic       exec;
        logic       div_start;
        logic [1:0] div_sel;
        logic       tot_latch;
        logic       axis_latch;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_plan;
        logic plan_zero;
        logic plan_fast;
        logic res_needed;
        logic out_full;
        logic div_done;
    } dp_status_t;

endpackage

### hw/rtl/mra_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mra_div #(
    parameter int W = mra_pkg::DIV_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted, diff;

    // Shift in one dividend bit and try the subtract
    always_comb begin
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = diff[W] ? shifted : diff;
            quo_next = {quo_reg[W-2:0], ~diff[W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

### hw/rtl/mra_ctrl.sv
// Controller state machine sequencing event execution and plan set-up.
`timescale 1ns / 1ps
module mra_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mra_pkg::dp_status_t   status,
    output mra_pkg::ctrl_cmd_t    cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_TOTW = 3'd2;
    localparam logic [2:0] ST_AX   = 3'd3;
    localparam logic [2:0] ST_AXW  = 3'd4;
    localparam logic [2:0] ST_AY   = 3'd5;
    localparam logic [2:0] ST_AYW  = 3'd6;

    logic [2:0] state_reg, state_next;

    // Decode the next state and the datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = mra_pkg::DSEL_TOTAL;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.is_plan) begin
                    if (status.plan_zero) begin
                        state_next = ST_IDLE;
                    end else if (status.plan_fast) begin
                        // step count needs no divider pass
                        cmd.tot_latch = 1'b1;
                        state_next    = ST_AX;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_TOTW;
                    end
                end else if (!(status.res_needed && status.out_full)) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TOTW: begin
                if (status.div_done) begin
                    cmd.tot_latch = 1'b1;
                    state_next    = ST_AX;
                end
            end
            ST_AX: begin
                cmd.div_sel   = mra_pkg::DSEL_X;
                cmd.div_start = 1'b1;
                state_next    = ST_AXW;
            end
            ST_AXW: begin
                cmd.div_sel = mra_pkg::DSEL_X;
                if (status.div_done) begin
                    cmd.axis_latch = 1'b1;
                    state_next     = ST_AY;
                end
            end
            ST_AY: begin
                cmd.div_sel   = mra_pkg::DSEL_Y;
                cmd.div_start = 1'b1;
                state_next    = ST_AYW;
            end
            ST_AYW: begin
                cmd.div_sel = mra_pkg::DSEL_Y;
                if (status.div_done) begin
                    cmd.axis_latch = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

### hw/rtl/mra_datapath.sv
// Datapath: event state, scroll accumulators, step generator, output register.
`timescale 1ns / 1ps
module mra_datapath #(
    parameter int ACC_WIDTH = mra_pkg::ACC_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mra_pkg::ctrl_cmd_t   cmd,
    output mra_pkg::dp_status_t  status,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [19:0]          cfg_data,
    input  logic [3:0]           s_opcode,
    input  logic signed [15:0]   s_x_delta,
    input  logic signed [15:0]   s_y_delta,
    input  logic signed [15:0]   s_scroll_delta,
    input  logic [7:0]           s_button_bits,
    input  logic                 s_pressed,
    input  logic [15:0]          s_duration_ms,
    input  logic [31:0]          s_now_ms,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_buttons,
    output logic signed [7:0]    m_x_motion,
    output logic signed [7:0]    m_y_motion,
    output logic signed [7:0]    m_vscroll,
    output logic signed [7:0]    m_hscroll,
    output logic [1:0]           m_link_change
);
    localparam int DW = mra_pkg::DIV_W;
    localparam int PW = mra_pkg::PLAN_W;

    // Configuration
    logic        hen_reg;
    logic [11:0] rate_reg;
    logic [19:0] thr_reg;

    // Captured item
    logic [3:0]         op_reg;
    logic signed [15:0] dx_reg, dy_reg, dz_reg;
    logic [7:0]         bits_reg;
    logic               pressed_reg;
    logic [15:0]        dur_reg;
    logic [31:0]        now_reg;

    // Event state
    logic [7:0]                  mask_reg, mask_next;
    logic signed [7:0]           px_reg, px_next, py_reg, py_next;
    logic signed [ACC_WIDTH-1:0] vacc_reg, vacc_next, hacc_reg, hacc_next;
    logic [31:0]                 last_reg, last_next;
    logic [1:0]                  link_reg, link_next;
    logic [PW-1:0]               total_reg, total_next, done_reg, done_next;
    logic signed [7:0]           step_reg [2];
    logic signed [7:0]           rem_reg [2];
    logic [PW-1:0]               spc_reg [2];
    logic [PW-1:0]               phase_reg [2];
    logic [PW-1:0]               phase_next [2];

    // Output register
    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg;
    logic [7:0]  ox_reg, oy_reg, ovs_reg, ohs_reg;
    logic [1:0]  olc_reg;

    // Divider
    logic [DW-1:0] dvd, dvs, quo;
    logic          div_done;

    // Operand magnitudes
    logic [15:0] ax, ay, amax, mag;
    logic [14:0] rate5;
    logic [12:0] iv;

    assign ax    = dx_reg[15] ? 16'(-dx_reg) : dx_reg;
    assign ay    = dy_reg[15] ? 16'(-dy_reg) : dy_reg;
    assign amax  = (ax > ay) ? ax : ay;
    assign rate5 = 15'(rate_reg) * 15'd5;
    assign iv    = (rate5[14:2] == 13'd0) ? 13'd1 : rate5[14:2];
    assign mag   = (cmd.div_sel == mra_pkg::DSEL_Y) ? ay : ax;

    // Step count of a zero-duration plan: ceil(max / 127) by reciprocal multiply
    logic [15:0] fx, frem;
    logic [25:0] fprod;
    logic [8:0]  fq0, fq;

    assign fx    = amax + 16'd126;
    assign fprod = 26'(fx) * 26'd516;
    assign fq0   = fprod[24:16];
    assign frem  = fx - 16'(fq0) * 16'd127;
    assign fq    = (frem >= 16'd127) ? fq0 + 9'd1 : fq0;

    // Pick divider operands for the step in progress
    always_comb begin
        if (cmd.div_sel == mra_pkg::DSEL_TOTAL) begin
            dvd = dur_reg;
            dvs = 16'(iv);
        end else if (mag >= 16'(total_reg)) begin
            dvd = mag;
            dvs = 16'(total_reg);
        end else begin
            dvd = 16'(total_reg);
            dvs = mag;
        end
    end

    mra_div #(.W(DW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    // Per-axis plan values from the divider result
    logic [15:0]       tot_q;
    logic [PW-1:0]     tot_sat;
    logic [6:0]        chunk;
    logic [20:0]       prod, left;
    logic [6:0]        left7;
    logic signed [7:0] ax_step, ax_rem;
    logic [PW-1:0]     ax_spc;
    logic              ax_neg;

    assign tot_q = (dur_reg == 16'd0) ? 16'(fq) : quo;

    always_comb begin
        if (tot_q > 16'(mra_pkg::PLAN_MAX)) begin
            tot_sat = mra_pkg::PLAN_MAX;
        end else if (tot_q == 16'd0) begin
            tot_sat = 14'd1;
        end else begin
            tot_sat = tot_q[PW-1:0];
        end
        ax_neg = (cmd.div_sel == mra_pkg::DSEL_Y) ? dy_reg[15] : dx_reg[15];
        chunk  = (quo > 16'd127) ? 7'd127 : quo[6:0];
        prod   = 21'(chunk) * 21'(total_reg - 14'd1);
        left   = 21'(mag) - prod;
        left7  = (left > 21'd127) ? 7'd127 : left[6:0];
        if (mag == 16'd0) begin
            ax_step = 8'sd0;
            ax_rem  = 8'sd0;
            ax_spc  = 14'd1;
        end else if (mag >= 16'(total_reg)) begin
            ax_step = ax_neg ? -$signed({1'b0, chunk}) : $signed({1'b0, chunk});
            ax_rem  = ax_neg ? -$signed({1'b0, left7}) : $signed({1'b0, left7});
            ax_spc  = 14'd1;
        end else begin
            ax_step = ax_neg ? -8'sd1 : 8'sd1;
            ax_rem  = ax_neg ? -8'sd1 : 8'sd1;
            ax_spc  = quo[PW-1:0];
        end
    end

    // Saturating accumulate and drain helpers
    function automatic logic signed [ACC_WIDTH-1:0] acc_add(
        input logic signed [ACC_WIDTH-1:0] acc,
        input logic signed [15:0]          d
    );
        logic signed [ACC_WIDTH:0] s;
        s = {acc[ACC_WIDTH-1], acc} + (ACC_WIDTH + 1)'(d);
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
            acc_add = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH - 1){1'b0}}}
                                   : {1'b0, {(ACC_WIDTH - 1){1'b1}}};
        end else begin
            acc_add = s[ACC_WIDTH-1:0];
        end
    endfunction

    function automatic logic signed [7:0] drain_chunk(
        input logic signed [ACC_WIDTH-1:0] acc
    );
        if (acc > ACC_WIDTH'(127)) begin
            drain_chunk = 8'sd127;
        end else if (acc < -ACC_WIDTH'(127)) begin
            drain_chunk = -8'sd127;
        end else begin
            drain_chunk = acc[7:0];
        end
    endfunction

    function automatic logic signed [7:0] clamp127(input logic signed [15:0] v);
        if (v > 16'sd127) begin
            clamp127 = 8'sd127;
        end else if (v < -16'sd127) begin
            clamp127 = -8'sd127;
        end else begin
            clamp127 = v[7:0];
        end
    endfunction

    // Event execution
    logic              plan_act, plan_final;
    logic              fire [2];
    logic signed [7:0] pv [2];
    logic signed [7:0] vch, hch;
    logic [31:0]       idle;
    logic [1:0]        lc;
    logic              paired;
    logic              load_out;
    logic [7:0]        rb, rx, ry, rv, rh;

    assign paired     = (link_reg != mra_pkg::LINK_DISC);
    assign plan_act   = (done_reg < total_reg);
    assign plan_final = (done_reg == total_reg - 14'd1);
    assign vch        = drain_chunk(vacc_reg);
    assign hch        = drain_chunk(hacc_reg);

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            fire[k] = (spc_reg[k] <= 14'd1) || (phase_reg[k] + 14'd1 == spc_reg[k]);
            pv[k]   = plan_final ? rem_reg[k] : (fire[k] ? step_reg[k] : 8'sd0);
        end
    end

    always_comb begin
        mask_next  = mask_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        vacc_next  = vacc_reg;
        hacc_next  = hacc_reg;
        last_next  = last_reg;
        link_next  = link_reg;
        total_next = total_reg;
        done_next  = done_reg;
        phase_next = phase_reg;
        load_out   = 1'b0;
        rb = '0; rx = '0; ry = '0; rv = '0; rh = '0;
        lc   = mra_pkg::LC_NONE;
        idle = '0;
        if (cmd.tot_latch) begin
            total_next    = tot_sat;
            done_next     = '0;
            phase_next[0] = '0;
            phase_next[1] = '0;
        end
        if (cmd.exec) begin
            unique case (op_reg)
                mra_pkg::OP_MOVE: begin
                    px_next   = clamp127(dx_reg);
                    py_next   = clamp127(dy_reg);
                    last_next = now_reg;
                end
                mra_pkg::OP_VSCROLL: begin
                    vacc_next = acc_add(vacc_reg, dz_reg);
                    last_next = now_reg;
                end
                mra_pkg::OP_HSCROLL: begin
                    if (hen_reg) begin
                        hacc_next = acc_add(hacc_reg, dz_reg);
                        last_next = now_reg;
                    end
                end
                mra_pkg::OP_BUTTON: begin
                    mask_next = pressed_reg ? (mask_reg | bits_reg) : (mask_reg & ~bits_reg);
                    last_next = now_reg;
                end
                mra_pkg::OP_MASK: begin
                    mask_next = bits_reg;
                    last_next = now_reg;
                end
                mra_pkg::OP_TICK: begin
                    if (paired) begin
                        rx = px_reg;
                        ry = py_reg;
                        if (plan_act) begin
                            rx = pv[0];
                            ry = pv[1];
                            for (int k = 0; k < 2; k++) begin
                                phase_next[k] = (phase_reg[k] + 14'd1 == spc_reg[k])
                                              ? '0 : phase_reg[k] + 14'd1;
                            end
                            done_next = done_reg + 14'd1;
                            if (done_reg + 14'd1 >= total_reg) begin
                                total_next = '0;
                                done_next  = '0;
                            end
                            last_next = now_reg;
                        end
                        if (vacc_reg != '0) begin
                            rv        = vch;
                            vacc_next = vacc_reg - ACC_WIDTH'(vch);
                            last_next = now_reg;
                        end
                        if (hen_reg && hacc_reg != '0) begin
                            rh        = hch;
                            hacc_next = hacc_reg - ACC_WIDTH'(hch);
                            last_next = now_reg;
                        end
                        idle = now_reg - last_next;
                        if (link_reg == mra_pkg::LINK_ACTIVE && idle >= 32'(thr_reg)) begin
                            link_next = mra_pkg::LINK_IDLE;
                            lc        = mra_pkg::LC_IDLE;
                        end else if (link_reg == mra_pkg::LINK_IDLE
                                     && idle < 32'(thr_reg)) begin
                            link_next = mra_pkg::LINK_ACTIVE;
                            lc        = mra_pkg::LC_ACTIVE;
                        end
                        rb       = mask_reg;
                        px_next  = '0;
                        py_next  = '0;
                        load_out = 1'b1;
                    end
                end
                mra_pkg::OP_LINK_UP: begin
                    link_next = mra_pkg::LINK_ACTIVE;
                    last_next = now_reg;
                    load_out  = 1'b1;
                end
                mra_pkg::OP_LINK_DN: begin
                    link_next = mra_pkg::LINK_DISC;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the report until the sink takes it
    always_comb begin
        ov_next = ov_reg;
        if (m_ready) begin
            ov_next = 1'b0;
        end
        if (load_out) begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hen_reg   <= 1'b0;
            rate_reg  <= 12'd12;
            thr_reg   <= 20'd5000;
            mask_reg  <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
            vacc_reg  <= '0;
            hacc_reg  <= '0;
            last_reg  <= '0;
            link_reg  <= mra_pkg::LINK_DISC;
            total_reg <= '0;
            done_reg  <= '0;
            ov_reg    <= 1'b0;
            for (int k = 0; k < 2; k++) begin
                step_reg[k]  <= '0;
                rem_reg[k]   <= '0;
                spc_reg[k]   <= 14'd1;
                phase_reg[k] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    mra_pkg::CFG_HSCROLL_EN: hen_reg  <= cfg_data[0];
                    mra_pkg::CFG_RATE:       rate_reg <= cfg_data[11:0];
                    mra_pkg::CFG_IDLE_THR:   thr_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            mask_reg  <= mask_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            vacc_reg  <= vacc_next;
            hacc_reg  <= hacc_next;
            last_reg  <= last_next;
            link_reg  <= link_next;
            total_reg <= total_next;
            done_reg  <= done_next;
            ov_reg    <= ov_next;
            for (int k = 0; k < 2; k++) begin
                phase_reg[k] <= phase_next[k];
            end
            if (cmd.axis_latch) begin
                if (cmd.div_sel == mra_pkg::DSEL_Y) begin
                    step_reg[1] <= ax_step;
                    rem_reg[1]  <= ax_rem;
                    spc_reg[1]  <= ax_spc;
                end else begin
                    step_reg[0] <= ax_step;
                    rem_reg[0]  <= ax_rem;
                    spc_reg[0]  <= ax_spc;
                end
            end
        end
        // Capture the accepted beat
        if (cmd.load_item) begin
            op_reg      <= s_opcode;
            dx_reg      <= s_x_delta;
            dy_reg      <= s_y_delta;
            dz_reg      <= s_scroll_delta;
            bits_reg    <= s_button_bits;
            pressed_reg <= s_pressed;
            dur_reg     <= s_duration_ms;
            now_reg     <= s_now_ms;
        end
        if (load_out) begin
            ob_reg  <= rb;
            ox_reg  <= rx;
            oy_reg  <= ry;
            ovs_reg <= rv;
            ohs_reg <= rh;
            olc_reg <= lc;
        end
    end

    assign status.is_plan    = (op_reg == mra_pkg::OP_PLAN);
    assign status.plan_zero  = (dx_reg == 16'sd0) && (dy_reg == 16'sd0);
    assign status.plan_fast  = (dur_reg == 16'd0);
    assign status.res_needed = (op_reg == mra_pkg::OP_LINK_UP)
                             || (op_reg == mra_pkg::OP_TICK && paired);
    assign status.out_full   = ov_reg;
    assign status.div_done   = div_done;

    assign m_valid       = ov_reg;
    assign m_buttons     = ob_reg;
    assign m_x_motion    = ox_reg;
    assign m_y_motion    = oy_reg;
    assign m_vscroll     = ovs_reg;
    assign m_hscroll     = ohs_reg;
    assign m_link_change = olc_reg;
endmodule

### hw/rtl/mouse_report_aggregator_top.sv
// Top level of the mouse report aggregator.
`timescale 1ns / 1ps
// Collects pointer events and emits one 6-field mouse report per tick while
// the link is paired, and a zero report on link up. One event is processed at
// a time. A planned move gets its step count and its two per-axis step sizes
// from three passes of one shared divider; with a zero duration the step
// count comes from a reciprocal multiply instead. A planned move with no
// motion on either axis ends without a divider pass.
// A finished report sits in the output register while the next event is
// accepted; an event that would make a report waits for that register to
// empty. Configuration writes (index 0 hscroll enable, 1 update rate,
// 2 idle threshold) are always taken and apply at once.
module mouse_report_aggregator_top #(
    parameter int ACC_WIDTH = mra_pkg::ACC_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_opcode,
    input  logic signed [15:0] s_x_delta,
    input  logic signed [15:0] s_y_delta,
    input  logic signed [15:0] s_scroll_delta,
    input  logic [7:0]         s_button_bits,
    input  logic               s_pressed,
    input  logic [15:0]        s_duration_ms,
    input  logic [31:0]        s_now_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_buttons,
    output logic signed [7:0]  m_x_motion,
    output logic signed [7:0]  m_y_motion,
    output logic signed [7:0]  m_vscroll,
    output logic signed [7:0]  m_hscroll,
    output logic [1:0]         m_link_change
);
    mra_pkg::ctrl_cmd_t  cmd;
    mra_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    mra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mra_datapath #(.ACC_WIDTH(ACC_WIDTH)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_opcode       (s_opcode),
        .s_x_delta      (s_x_delta),
        .s_y_delta      (s_y_delta),
        .s_scroll_delta (s_scroll_delta),
        .s_button_bits  (s_button_bits),
        .s_pressed      (s_pressed),
        .s_duration_ms  (s_duration_ms),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_buttons      (m_buttons),
        .m_x_motion     (m_x_motion),
        .m_y_motion     (m_y_motion),
        .m_vscroll      (m_vscroll),
        .m_hscroll      (m_hscroll),
        .m_link_change  (m_link_change)
    );

    // One event in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an event is in flight");

    // Link change code stays in range
    a_lc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_link_change != 2'd3)
        else $error("bad link change code");

    // Motion never reaches -128
    a_x_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_x_motion != 8'sh80 && m_y_motion != 8'sh80))
        else $error("motion out of range");
endmodule
